/* design/plt_pkg.sv */
// plt_pkg: command codes, sequencer states and field widths of the positional list table
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package plt_pkg;

    // fixed field widths of the channels
    localparam int CMD_W  = 3;
    localparam int POS_W  = 8;
    localparam int ELEM_W = 32;
    localparam int IDX_W  = 8;
    localparam int LEN_W  = 8;

    // index reported when a search misses or the command is not a search
    localparam logic [IDX_W-1:0] NO_INDEX = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_SEARCH = 3'd2,
        CMD_MODIFY = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_PUT,
        ST_DOWN,
        ST_SRCH,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* design/plt_req_if.sv */
// plt_req_if: command channel of the positional list table (valid/ready plus payload)
// depends on plt_pkg for the field widths
`default_nettype none

interface plt_req_if;
    logic                                valid;
    logic                                ready;
    logic        [plt_pkg::CMD_W-1:0]    cmd;
    logic        [plt_pkg::POS_W-1:0]    position;
    logic signed [plt_pkg::ELEM_W-1:0]   element;

    modport source (output valid, output cmd, output position, output element, input ready);
    modport sink   (input valid, input cmd, input position, input element, output ready);
endinterface

`default_nettype wire

/* design/plt_rsp_if.sv */
// plt_rsp_if: result channel of the positional list table (valid/ready plus payload)
// depends on plt_pkg for the field widths
`default_nettype none

interface plt_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               ok;
    logic signed [plt_pkg::IDX_W-1:0]   found_index;
    logic        [plt_pkg::LEN_W-1:0]   list_length;

    modport source (output valid, output ok, output found_index, output list_length,
                    input ready);
    modport sink   (input valid, input ok, input found_index, input list_length,
                    output ready);
endinterface

`default_nettype wire

/* design/plt_ram.sv */
// plt_ram: word store of the list, one write port and one read port, registered read data
// no dependencies
`default_nettype none

module plt_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
    output      logic [WIDTH-1:0]             rd_data,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  wire logic [WIDTH-1:0]             wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/positional_list_table.sv */
// positional_list_table: ordered list of signed words in a memory, one command per transfer.
// Modify, clear, unknown and rejected commands go straight to the done state; insert shifts
// the entries at and above the position up and writes the word; delete shifts the entries
// above the position down; search reads from entry 0 to a hit or the end. One item at a
// time: the next command is taken the cycle after its result loads, and a result held by
// the sink stalls that load. Reset clears the entry count and the handshake state; the
// memory needs no clearing pass. Depends on plt_pkg, the two channel interfaces and plt_ram
`default_nettype none

module positional_list_table #(
    parameter int CAPACITY = 128
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    plt_req_if.sink    request,
    plt_rsp_if.source  response
);

    import plt_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // control state
    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              resp_valid_reg, resp_valid_next;

    // payload state
    logic [CW-1:0]     cur_reg, cur_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [ELEM_W-1:0] word_reg, word_next;
    logic              res_ok_reg, res_ok_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic              resp_ok_reg, resp_ok_next;
    logic [IDX_W-1:0]  resp_idx_reg, resp_idx_next;
    logic [LEN_W-1:0]  resp_len_reg, resp_len_next;

    // memory port
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [ELEM_W-1:0] rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [ELEM_W-1:0] wr_data;

    // shared conditions
    logic [CMPW-1:0]   pos_c;
    logic [CMPW-1:0]   cnt_c;
    logic              ins_ok;
    logic              pos_ok;
    logic              up_more;
    logic              walk_more;
    logic              hit;
    logic              out_free;

    plt_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ELEM_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // command checks against the current count, walk and output conditions
    assign pos_c     = CMPW'(request.position);
    assign cnt_c     = CMPW'(count_reg);
    assign ins_ok    = (pos_c <= cnt_c) && (count_reg < CW'(CAPACITY));
    assign pos_ok    = pos_c < cnt_c;
    assign up_more   = cur_reg > pos_reg;
    assign walk_more = cur_reg < count_reg;
    assign hit       = pend_valid_reg && (rd_data == word_reg);
    assign out_free  = !resp_valid_reg || response.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    case (request.cmd)
                        CMD_INSERT: state_next = ins_ok ? ST_UP : ST_DONE;
                        CMD_DELETE: state_next = pos_ok ? ST_DOWN : ST_DONE;
                        CMD_SEARCH: state_next = ST_SRCH;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_UP:   state_next = up_more ? ST_UP : ST_PUT;
            ST_PUT:  state_next = ST_DONE;
            ST_DOWN: state_next = walk_more ? ST_DOWN : ST_DONE;
            ST_SRCH: state_next = (hit || !walk_more) ? ST_DONE : ST_SRCH;
            ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath, memory port and result
    always_comb
    begin
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        resp_valid_next = resp_valid_reg;
        cur_next        = cur_reg;
        pend_addr_next  = pend_addr_reg;
        pos_next        = pos_reg;
        word_next       = word_reg;
        res_ok_next     = res_ok_reg;
        res_idx_next    = res_idx_reg;
        resp_ok_next    = resp_ok_reg;
        resp_idx_next   = resp_idx_reg;
        resp_len_next   = resp_len_reg;
        rd_en           = 1'b0;
        rd_addr         = AW'(cur_reg);
        wr_en           = 1'b0;
        wr_addr         = pend_addr_reg;
        wr_data         = rd_data;

        // result register drains on its own transfer
        if (resp_valid_reg && response.ready)
        begin
            resp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    pos_next        = CW'(pos_c);
                    word_next       = request.element;
                    pend_valid_next = 1'b0;
                    res_ok_next     = 1'b0;
                    res_idx_next    = NO_INDEX;
                    case (request.cmd)
                        CMD_INSERT: cur_next = count_reg;
                        CMD_DELETE: cur_next = CW'(pos_c) + CW'(1);
                        CMD_SEARCH: cur_next = '0;
                        CMD_MODIFY:
                        begin
                            if (pos_ok)
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = AW'(pos_c);
                                wr_data     = request.element;
                                res_ok_next = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next  = '0;
                            res_ok_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end

            // shift up: read entry cur-1, write it one place higher next cycle
            ST_UP:
            begin
                wr_en = pend_valid_reg;
                if (up_more)
                begin
                    rd_en           = 1'b1;
                    rd_addr         = AW'(cur_reg - CW'(1));
                    pend_addr_next  = AW'(cur_reg);
                    pend_valid_next = 1'b1;
                    cur_next        = cur_reg - CW'(1);
                end
                else
                begin
                    pend_valid_next = 1'b0;
                end
            end

            // drop the new word into the freed slot
            ST_PUT:
            begin
                wr_en       = 1'b1;
                wr_addr     = AW'(pos_reg);
                wr_data     = word_reg;
                count_next  = count_reg + CW'(1);
                res_ok_next = 1'b1;
            end

            // shift down: read entry cur, write it one place lower next cycle
            ST_DOWN:
            begin
                wr_en = pend_valid_reg;
                if (walk_more)
                begin
                    rd_en           = 1'b1;
                    rd_addr         = AW'(cur_reg);
                    pend_addr_next  = AW'(cur_reg - CW'(1));
                    pend_valid_next = 1'b1;
                    cur_next        = cur_reg + CW'(1);
                end
                else
                begin
                    pend_valid_next = 1'b0;
                    count_next      = count_reg - CW'(1);
                    res_ok_next     = 1'b1;
                end
            end

            // linear search, each compare uses the read data in the cycle after its read
            ST_SRCH:
            begin
                if (hit)
                begin
                    res_ok_next     = 1'b1;
                    res_idx_next    = IDX_W'(pend_addr_reg);
                    pend_valid_next = 1'b0;
                end
                else if (walk_more)
                begin
                    rd_en           = 1'b1;
                    rd_addr         = AW'(cur_reg);
                    pend_addr_next  = AW'(cur_reg);
                    pend_valid_next = 1'b1;
                    cur_next        = cur_reg + CW'(1);
                end
                else
                begin
                    pend_valid_next = 1'b0;
                end
            end

            // hand the result to the output register when it is free
            ST_DONE:
            begin
                if (out_free)
                begin
                    resp_valid_next = 1'b1;
                    resp_ok_next    = res_ok_reg;
                    resp_idx_next   = res_idx_reg;
                    resp_len_next   = LEN_W'(count_reg);
                end
            end

            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            resp_valid_reg <= resp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        pend_addr_reg <= pend_addr_next;
        pos_reg       <= pos_next;
        word_reg      <= word_next;
        res_ok_reg    <= res_ok_next;
        res_idx_reg   <= res_idx_next;
        resp_ok_reg   <= resp_ok_next;
        resp_idx_reg  <= resp_idx_next;
        resp_len_reg  <= resp_len_next;
    end

    // channel outputs
    assign request.ready        = (state_reg == ST_IDLE);
    assign response.valid       = resp_valid_reg;
    assign response.ok          = resp_ok_reg;
    assign response.found_index = resp_idx_reg;
    assign response.list_length = resp_len_reg;

    // count stays within the store
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // read and write never meet on one entry in a cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en && (rd_addr == wr_addr)))
        else $error("memory read and write to the same entry");

    // a pending shift-up write always lands above the insert position
    a_up_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP && pend_valid_reg) |-> (CW'(pend_addr_reg) > pos_reg))
        else $error("shift-up write at or below insert position");

    // a new result comes only out of the done state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(resp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the done state");

endmodule

`default_nettype wire

/* tb/sv/positional_list_table_test.sv */
`timescale 1ns / 100ps
// positional_list_table_test: self-checking bench for the positional list table, with a shadow
// list that works out each reply, random idles on both channels and a cycle watchdog
// depends on plt_pkg, plt_req_if, plt_rsp_if and the positional_list_table top level

module positional_list_table_test;
    import plt_pkg::*;

    localparam int CAPACITY      = 128;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = CAPACITY + 16;
    localparam int REPORT_LIMIT  = 10;
    localparam int MIX_ITEMS     = 400;

    // command codes the block leaves undefined
    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam logic signed [ELEM_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
    localparam logic signed [ELEM_W-1:0] WORD_MIN  = 32'h8000_0000;
    localparam logic signed [ELEM_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                    ok;
        logic signed [IDX_W-1:0] found_index;
        logic        [LEN_W-1:0] list_length;
    } reply_t;

    logic clk;
    logic rst_n;

    plt_req_if request_bus ();
    plt_rsp_if reply_bus ();

    positional_list_table #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_bus),
        .response (reply_bus)
    );

    // shadow copy of the list
    logic signed [ELEM_W-1:0] shadow_words [CAPACITY];
    int                       shadow_count = 0;

    reply_t awaited_replies [$];
    int     mismatches     = 0;
    int     replies_seen   = 0;
    int     cycles         = 0;
    bit     no_idle        = 1'b0;
    int     cmd_tally [8];
    int     search_hits    = 0;
    int     rejects        = 0;
    int     peak_length    = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d replies still awaited", cycles,
                 awaited_replies.size());
        $display("positional_list_table_test: done, errors");
        $finish;
    end

    // apply one command to the shadow list and return the reply it must give
    function automatic reply_t list_apply(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                                          logic signed [ELEM_W-1:0] word);
        reply_t r;
        int     i;
        r.ok          = 1'b0;
        r.found_index = NO_INDEX;
        case (op)
            CMD_INSERT:
                if (pos <= shadow_count && shadow_count < CAPACITY)
                begin
                    for (i = shadow_count; i > pos; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[pos] = word;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            CMD_DELETE:
                if (pos < shadow_count)
                begin
                    for (i = pos + 1; i < shadow_count; i++)
                        shadow_words[i-1] = shadow_words[i];
                    shadow_count--;
                    r.ok = 1'b1;
                end
            CMD_SEARCH:
                for (i = 0; i < shadow_count && !r.ok; i++)
                begin
                    if (shadow_words[i] == word)
                    begin
                        r.ok          = 1'b1;
                        r.found_index = IDX_W'(i);
                    end
                end
            CMD_MODIFY:
                if (pos < shadow_count)
                begin
                    shadow_words[pos] = word;
                    r.ok = 1'b1;
                end
            CMD_CLEAR:
            begin
                shadow_count = 0;
                r.ok         = 1'b1;
            end
            default: ;
        endcase
        r.list_length = LEN_W'(shadow_count);
        return r;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int idle_length();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // word to insert or look for: often one already in the list, some corners, some noise
    function automatic logic signed [ELEM_W-1:0] pick_word();
        int r;
        r = $urandom_range(99, 0);
        if (r < 35 && shadow_count > 0)
            return shadow_words[$urandom_range(shadow_count - 1, 0)];
        if (r < 55)
        begin
            case ($urandom_range(5, 0))
                0: return '0;
                1: return WORD_ONES;
                2: return WORD_MAX;
                3: return WORD_MIN;
                4: return 32'sd1;
                default: return $urandom_range(15, 0);
            endcase
        end
        return $urandom();
    endfunction

    // position: mostly within 0..top, sometimes anywhere in the field
    function automatic logic [POS_W-1:0] pick_position(int top);
        if ($urandom_range(99, 0) < 85)
            return POS_W'($urandom_range(top, 0));
        return POS_W'($urandom_range(255, 0));
    endfunction

    // drive one command and wait for its transfer
    task automatic send_command(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                                logic signed [ELEM_W-1:0] word);
        int     gap;
        reply_t want;
        gap = idle_length();
        if (gap > 0)
        begin
            @(negedge clk);
            request_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        request_bus.valid    <= 1'b1;
        request_bus.cmd      <= op;
        request_bus.position <= pos;
        request_bus.element  <= word;
        do
            @(posedge clk);
        while (!request_bus.ready);
        want = list_apply(op, pos, word);
        awaited_replies.push_back(want);
        cmd_tally[op]++;
        if (op == CMD_SEARCH && want.ok)
            search_hits++;
        else if (op != CMD_SEARCH && !want.ok)
            rejects++;
        if (shadow_count > peak_length)
            peak_length = shadow_count;
    endtask

    task automatic note_failure(string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // result side: random back-pressure
    initial
    begin
        int hold;
        hold = 0;
        reply_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                reply_bus.ready <= 1'b0;
                hold--;
            end
            else
            begin
                reply_bus.ready <= 1'b1;
                if (!no_idle && $urandom_range(3, 0) == 0)
                    hold = idle_length();
            end
        end
    end

    // compare each result transfer with the oldest awaited reply
    initial
    begin
        reply_t got;
        reply_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && reply_bus.valid && reply_bus.ready)
            begin
                got.ok          = reply_bus.ok;
                got.found_index = reply_bus.found_index;
                got.list_length = reply_bus.list_length;
                replies_seen++;
                if (awaited_replies.size() == 0)
                    note_failure($sformatf("reply with none awaited: ok=%0b idx=%0d len=%0d",
                                           got.ok, got.found_index, got.list_length));
                else
                begin
                    want = awaited_replies.pop_front();
                    if (got.ok !== want.ok || got.found_index !== want.found_index ||
                        got.list_length !== want.list_length)
                        note_failure($sformatf(
                            "reply %0d: ok=%0b idx=%0d len=%0d, wanted ok=%0b idx=%0d len=%0d",
                            replies_seen, got.ok, got.found_index, got.list_length,
                            want.ok, want.found_index, want.list_length));
                end
            end
        end
    end

    // every command against an empty list
    task automatic test_empty_list();
        send_command(CMD_DELETE, 8'd0, '0);
        send_command(CMD_MODIFY, 8'd0, WORD_MAX);
        send_command(CMD_SEARCH, 8'd0, '0);
        send_command(CMD_CLEAR, 8'd0, '0);
        send_command(CMD_INSERT, 8'd1, 32'sd7);
        send_command(CMD_SPARE_7, 8'd255, WORD_ONES);
    endtask

    // field extremes, duplicates and the reject cases on a short list
    task automatic test_edge_cases();
        send_command(CMD_INSERT, 8'd0, WORD_MAX);
        send_command(CMD_INSERT, 8'd1, WORD_MIN);
        send_command(CMD_INSERT, 8'd0, WORD_ONES);
        send_command(CMD_INSERT, 8'd4, 32'sd3);
        send_command(CMD_INSERT, 8'd3, '0);
        send_command(CMD_INSERT, 8'd1, WORD_ONES);
        send_command(CMD_SEARCH, 8'd0, WORD_ONES);
        send_command(CMD_SEARCH, 8'd9, WORD_MIN);
        send_command(CMD_SEARCH, 8'd0, 32'sd12345);
        send_command(CMD_MODIFY, 8'd5, 32'sd1);
        send_command(CMD_MODIFY, 8'd255, 32'sd1);
        send_command(CMD_MODIFY, 8'd4, WORD_MIN);
        send_command(CMD_SEARCH, 8'd0, WORD_MIN);
        send_command(CMD_DELETE, 8'd5, '0);
        send_command(CMD_DELETE, 8'd4, '0);
        send_command(CMD_DELETE, 8'd0, '0);
        send_command(CMD_SPARE_6, 8'd128, WORD_MIN);
        send_command(CMD_INSERT, 8'd128, 32'sd5);
        send_command(CMD_CLEAR, 8'd77, WORD_ONES);
    endtask

    // grow the list to capacity, then hit the full-store rejects and the top entry
    task automatic test_fill_to_capacity();
        no_idle = ($urandom_range(1, 0) == 0);
        while (shadow_count < CAPACITY)
        begin
            if ($urandom_range(9, 0) == 0)
                send_command(CMD_SEARCH, POS_W'($urandom_range(255, 0)), pick_word());
            else
                send_command(CMD_INSERT, POS_W'($urandom_range(shadow_count, 0)), pick_word());
        end
        no_idle = 1'b0;
        send_command(CMD_INSERT, 8'd0, WORD_MAX);
        send_command(CMD_INSERT, 8'(CAPACITY), WORD_MIN);
        send_command(CMD_INSERT, 8'd200, 32'sd9);
        send_command(CMD_SEARCH, 8'd0, shadow_words[CAPACITY-1]);
        send_command(CMD_MODIFY, 8'(CAPACITY - 1), 32'h1357_9BDF);
        send_command(CMD_SEARCH, 8'd0, 32'h1357_9BDF);
        send_command(CMD_MODIFY, 8'(CAPACITY), '0);
        send_command(CMD_DELETE, 8'(CAPACITY), '0);
        send_command(CMD_DELETE, 8'(CAPACITY - 1), '0);
        send_command(CMD_DELETE, 8'd0, '0);
        send_command(CMD_INSERT, 8'(shadow_count), WORD_MIN);
        send_command(CMD_INSERT, 8'd0, WORD_MAX);
        send_command(CMD_SEARCH, 8'd0, WORD_MIN);
    endtask

    // random mix of commands with the list length wandering
    task automatic test_random_mix();
        int               n;
        int               r;
        logic [CMD_W-1:0] spare;
        for (n = 0; n < MIX_ITEMS; n++)
        begin
            if (n % 40 == 0)
                no_idle = ($urandom_range(2, 0) == 0);
            r = $urandom_range(99, 0);
            if (r < 38)
                send_command(CMD_INSERT, pick_position(shadow_count), pick_word());
            else if (r < 62)
                send_command(CMD_DELETE, pick_position(shadow_count), $urandom());
            else if (r < 80)
                send_command(CMD_SEARCH, POS_W'($urandom_range(255, 0)), pick_word());
            else if (r < 90)
                send_command(CMD_MODIFY, pick_position(shadow_count), pick_word());
            else if (r < 91)
                send_command(CMD_CLEAR, POS_W'($urandom_range(255, 0)), $urandom());
            else if (r < 95)
            begin
                case ($urandom_range(2, 0))
                    0: spare = CMD_SPARE_5;
                    1: spare = CMD_SPARE_6;
                    default: spare = CMD_SPARE_7;
                endcase
                send_command(spare, POS_W'($urandom_range(255, 0)), $urandom());
            end
            else
                send_command(CMD_INSERT, POS_W'($urandom_range(255, shadow_count + 1)),
                             pick_word());
        end
        no_idle = 1'b0;
    endtask

    // empty the list one entry at a time, then poke the empty list
    task automatic test_drain();
        while (shadow_count > 0)
        begin
            if ($urandom_range(4, 0) == 0)
                send_command(CMD_SEARCH, 8'd0, pick_word());
            else
                send_command(CMD_DELETE, POS_W'($urandom_range(shadow_count - 1, 0)),
                             $urandom());
        end
        send_command(CMD_DELETE, 8'd0, '0);
        send_command(CMD_SEARCH, 8'd0, '0);
        send_command(CMD_SPARE_5, 8'd0, '0);
        send_command(CMD_CLEAR, 8'd0, '0);
    endtask

    // stimulus sequence
    initial
    begin
        rst_n                = 1'b0;
        request_bus.valid    = 1'b0;
        request_bus.cmd      = CMD_INSERT;
        request_bus.position = '0;
        request_bus.element  = '0;
        foreach (cmd_tally[i])
            cmd_tally[i] = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_edge_cases();
        test_fill_to_capacity();
        test_random_mix();
        test_drain();

        @(negedge clk);
        request_bus.valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("ran %0d: ins %0d del %0d srch %0d mod %0d clr %0d other %0d",
                 cmd_tally.sum(), cmd_tally[CMD_INSERT], cmd_tally[CMD_DELETE],
                 cmd_tally[CMD_SEARCH], cmd_tally[CMD_MODIFY], cmd_tally[CMD_CLEAR],
                 cmd_tally[CMD_SPARE_5] + cmd_tally[CMD_SPARE_6] + cmd_tally[CMD_SPARE_7]);
        $display("peak length %0d, hits %0d, rejects %0d, replies %0d, mismatches %0d",
                 peak_length, search_hits, rejects, replies_seen, mismatches);
        if (mismatches == 0)
            $display("positional_list_table_test: done, clean");
        else
            $display("positional_list_table_test: done, errors");
        $finish;
    end

endmodule

/* files.f */
design/plt_pkg.sv
design/plt_req_if.sv
design/plt_rsp_if.sv
design/plt_ram.sv
design/positional_list_table.sv
tb/sv/positional_list_table_test.sv
